// ----- src/ccio_pkg.sv -----
// shared constants, mode codes and helper functions for the coin and credit controller
// no dependencies
`default_nettype none

package ccio_pkg;

    // access modes selected by command writes
    localparam logic [2:0] MODE_NOP     = 3'd0;
    localparam logic [2:0] MODE_COINAGE = 3'd1;
    localparam logic [2:0] MODE_CREDITS = 3'd2;
    localparam logic [2:0] MODE_PORTS   = 3'd5;

    // port 0 bit positions (active low)
    localparam int BIT_FIRE1   = 0;
    localparam int BIT_FIRE2   = 1;
    localparam int BIT_START1  = 2;
    localparam int BIT_START2  = 3;
    localparam int BIT_COIN1   = 4;
    localparam int BIT_COIN2   = 5;
    localparam int BIT_SERVICE = 6;
    localparam int BIT_TEST    = 7;

    localparam logic [7:0] TEST_BYTE      = 8'hBB;
    localparam logic [6:0] CREDIT_CEILING = 7'd99;
    localparam logic [6:0] FREE_PLAY      = 7'd100;
    localparam logic [7:0] PORT0_RESET    = 8'hFF;
    localparam logic [2:0] COINAGE_WRITES = 3'd4;

    // credit count to packed bcd, tens found by reciprocal multiply (exact below 128)
    function automatic logic [7:0] to_bcd(input logic [6:0] c);
        logic [14:0] p;
        logic [3:0]  tens;
        logic [6:0]  ones;
        p    = 15'(c) * 15'd205;
        tens = p[14:11];
        ones = c - 7'({3'b000, tens} * 7'd10);
        return {tens, ones[3:0]};
    endfunction

    // read sequence advance: (s + 1) mod 3
    function automatic logic [2:0] seq_advance(input logic [2:0] s);
        logic [2:0] n;
        unique case (s)
            3'd0:    n = 3'd1;
            3'd1:    n = 3'd2;
            3'd2:    n = 3'd0;
            3'd3:    n = 3'd1;
            3'd4:    n = 3'd2;
            3'd5:    n = 3'd0;
            3'd6:    n = 3'd1;
            3'd7:    n = 3'd2;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- src/coin_credit_io_controller.sv -----
// Each access passes the input register and then the result register, which drives m_valid.
// Throughput: one bus access per cycle while the result side does not stall; the only state
// loop is the credit/coin update logic between the input register and the result register.
// Stalls on the result side fill the input register, then hold s_ready low.
// Reset (aresetn low, synchronous) empties both registers and restores the controller state. ccio_pkg.
`default_nettype none

module coin_credit_io_controller (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_func,
    input  wire logic [7:0] s_write_data,
    input  wire logic [7:0] s_port0_value,
    input  wire logic [7:0] s_port1_value,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_read_data
);

    // input register
    logic       in_valid_reg;
    logic       in_func_reg;
    logic [7:0] in_wdata_reg;
    logic [7:0] in_p0_reg;
    logic [7:0] in_p1_reg;

    // result register
    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic [7:0] out_data_next;

    // controller state
    logic [6:0] credit_reg, credit_next;
    logic [3:0] coin0_reg, coin0_next;
    logic [3:0] coin1_reg, coin1_next;
    logic [2:0] cpc0_reg, cpc0_next;
    logic [2:0] cpc1_reg, cpc1_next;
    logic [2:0] cpn0_reg, cpn0_next;
    logic [2:0] cpn1_reg, cpn1_next;
    logic [2:0] mode_reg, mode_next;
    logic [2:0] seq_reg, seq_next;
    logic [7:0] prev_p0_reg, prev_p0_next;

    logic       advance;
    logic       out_free;
    logic [2:0] wval;
    logic [7:0] fell;
    logic [7:0] evt;
    logic [6:0] cr_a, cr_b, cr_c, cr_d;
    logic [3:0] c0_inc, c1_inc;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign m_valid  = out_valid_reg;
    assign m_read_data = out_data_reg;

    assign wval = in_wdata_reg[2:0];
    assign fell = prev_p0_reg & ~in_p0_reg;
    assign evt  = in_p0_reg | ~prev_p0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            credit_reg    <= '0;
            coin0_reg     <= '0;
            coin1_reg     <= '0;
            cpc0_reg      <= 3'd1;
            cpc1_reg      <= 3'd1;
            cpn0_reg      <= 3'd1;
            cpn1_reg      <= 3'd1;
            mode_reg      <= ccio_pkg::MODE_NOP;
            seq_reg       <= '0;
            prev_p0_reg   <= ccio_pkg::PORT0_RESET;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            credit_reg  <= credit_next;
            coin0_reg   <= coin0_next;
            coin1_reg   <= coin1_next;
            cpc0_reg    <= cpc0_next;
            cpc1_reg    <= cpc1_next;
            cpn0_reg    <= cpn0_next;
            cpn1_reg    <= cpn1_next;
            mode_reg    <= mode_next;
            seq_reg     <= seq_next;
            prev_p0_reg <= prev_p0_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_func_reg  <= s_func;
            in_wdata_reg <= s_write_data;
            in_p0_reg    <= s_port0_value;
            in_p1_reg    <= s_port1_value;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    always_comb begin
        credit_next   = credit_reg;
        coin0_next    = coin0_reg;
        coin1_next    = coin1_reg;
        cpc0_next     = cpc0_reg;
        cpc1_next     = cpc1_reg;
        cpn0_next     = cpn0_reg;
        cpn1_next     = cpn1_reg;
        mode_next     = mode_reg;
        seq_next      = seq_reg;
        prev_p0_next  = prev_p0_reg;
        out_data_next = '0;
        cr_a          = credit_reg;
        cr_b          = credit_reg;
        cr_c          = credit_reg;
        cr_d          = credit_reg;
        c0_inc        = coin0_reg;
        c1_inc        = coin1_reg;

        if (advance) begin
            if (in_func_reg) begin
                if (mode_reg == ccio_pkg::MODE_COINAGE && seq_reg != 3'd0) begin
                    // coinage data, stored by remaining write count
                    unique case (seq_reg)
                        3'd4:    cpc0_next = wval;
                        3'd3:    cpn0_next = wval;
                        3'd2:    cpc1_next = wval;
                        3'd1:    cpn1_next = wval;
                        default: ;
                    endcase
                    seq_next = seq_reg - 3'd1;
                end else begin
                    seq_next = '0;
                    unique case (wval)
                        ccio_pkg::MODE_COINAGE: begin
                            mode_next   = ccio_pkg::MODE_COINAGE;
                            credit_next = '0;
                            seq_next    = ccio_pkg::COINAGE_WRITES;
                        end
                        ccio_pkg::MODE_CREDITS, ccio_pkg::MODE_PORTS: begin
                            mode_next = wval;
                        end
                        default: ;
                    endcase
                end
            end else begin
                seq_next = ccio_pkg::seq_advance(seq_reg);
                if (mode_reg == ccio_pkg::MODE_PORTS) begin
                    if (seq_reg == 3'd0) begin
                        out_data_next = in_p0_reg;
                    end else if (seq_reg == 3'd1) begin
                        out_data_next = in_p1_reg;
                    end
                end else if (mode_reg == ccio_pkg::MODE_CREDITS) begin
                    if (seq_reg == 3'd0) begin
                        if (cpc0_reg != 3'd0) begin
                            if (credit_reg < ccio_pkg::CREDIT_CEILING) begin
                                // coin slot 1
                                if (fell[ccio_pkg::BIT_COIN1]) begin
                                    c0_inc = coin0_reg + 4'd1;
                                    if (c0_inc >= {1'b0, cpc0_reg}) begin
                                        c0_inc = c0_inc - {1'b0, cpc0_reg};
                                        cr_a   = credit_reg + {4'b0000, cpn0_reg};
                                    end
                                end
                                cr_b = cr_a;
                                // coin slot 2
                                if (fell[ccio_pkg::BIT_COIN2]) begin
                                    c1_inc = coin1_reg + 4'd1;
                                    if (c1_inc >= {1'b0, cpc1_reg}) begin
                                        c1_inc = c1_inc - {1'b0, cpc1_reg};
                                        cr_b   = cr_a + {4'b0000, cpn1_reg};
                                    end
                                end
                                cr_c = cr_b;
                                if (fell[ccio_pkg::BIT_SERVICE]) begin
                                    cr_c = cr_b + 7'd1;
                                end
                            end
                        end else begin
                            cr_c = ccio_pkg::FREE_PLAY;
                        end
                        // start buttons charge credits
                        cr_d = cr_c;
                        if (fell[ccio_pkg::BIT_START1] && cr_c != 7'd0) begin
                            cr_d = cr_c - 7'd1;
                        end else if (fell[ccio_pkg::BIT_START2] && cr_c >= 7'd2) begin
                            cr_d = cr_c - 7'd2;
                        end
                        credit_next = cr_d;
                        coin0_next  = c0_inc;
                        coin1_next  = c1_inc;
                        if (!in_p0_reg[ccio_pkg::BIT_TEST]) begin
                            out_data_next = ccio_pkg::TEST_BYTE;
                        end else begin
                            out_data_next = ccio_pkg::to_bcd(cr_d);
                        end
                    end else if (seq_reg == 3'd1) begin
                        out_data_next = {2'b00, in_p0_reg[ccio_pkg::BIT_FIRE1],
                                         evt[ccio_pkg::BIT_FIRE1], in_p1_reg[3:0]};
                    end else if (seq_reg == 3'd2) begin
                        out_data_next = {2'b00, in_p0_reg[ccio_pkg::BIT_FIRE2],
                                         evt[ccio_pkg::BIT_FIRE2], in_p1_reg[7:4]};
                        prev_p0_next  = in_p0_reg;
                    end
                end
            end
        end
    end

`ifndef ASSERT_OFF
    // the sequence counter never leaves its coinage range
    a_seq_range: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_reg <= ccio_pkg::COINAGE_WRITES)
        else $error("sequence count out of range");

    // a pending coinage write count implies set-coinage mode
    a_seq_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_reg >= 3'd3 |-> mode_reg == ccio_pkg::MODE_COINAGE)
        else $error("coinage count outside set-coinage mode");

    // a write transfer always returns zero
    a_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_func_reg |=> m_valid && m_read_data == 8'h00)
        else $error("write returned nonzero data");

    // input side only stalls when both registers are full and the output is held
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled without backpressure");
`endif

endmodule

`default_nettype wire
